// ----- rtl/sht_pkg.sv -----
// Shared types and constants for the scoped symbol hash table.
package sht_pkg;

  // Request codes.
  localparam logic OP_INTERN  = 1'b0;
  localparam logic OP_RESOLVE = 1'b1;

  // Hash arithmetic: scope*31 + name of two 16-bit values fits in 21 bits.
  localparam int HASH_W   = 21;
  localparam int KEY_W    = 32;
  localparam int ID_OUT_W = 12;

  typedef struct packed {
    logic        op;
    logic [15:0] scope_id;
    logic [15:0] name_id;
  } sht_req_t;

  typedef struct packed {
    logic [ID_OUT_W-1:0] entry_id;
    logic                found;
    logic                full_res;
  } sht_rsp_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_BKT_RD,
    ST_BKT_EV,
    ST_KEY_EV,
    ST_NODE_CHK,
    ST_NODE_EV,
    ST_NKEY_EV,
    ST_NODE_W2,
    ST_DONE
  } sht_state_t;

endpackage

// ----- rtl/sht_ram.sv -----
// Single-port-write, single-port-read synchronous RAM with registered read data.
module sht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/sht_hash.sv -----
// Key hash and bucket index reduction by reciprocal multiplication for a non-power-of-two bucket count.
module sht_hash #(
  parameter int BUCKETS = 4096
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [15:0]                scope_id,
  input  logic [15:0]                name_id,
  output logic                       done,
  output logic [$clog2(BUCKETS)-1:0] bidx
);
  import sht_pkg::*;

  localparam int  BIW  = $clog2(BUCKETS);
  localparam bit  POW2 = (BUCKETS & (BUCKETS - 1)) == 0;
  localparam int  SH   = HASH_W + BIW;
  localparam int  MW   = HASH_W + 1;
  localparam int  PRW  = HASH_W + MW;
  localparam int  QDW  = HASH_W + BIW;
  // Rounded-up reciprocal; exact quotient for every hash below 2**HASH_W.
  localparam longint unsigned RECIP =
    ((64'd1 << SH) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);

  logic [HASH_W-1:0] rem;
  logic [HASH_W-1:0] quo;
  logic [1:0]        phase;
  logic [HASH_W-1:0] hash;
  logic [PRW-1:0]    prod;
  logic [QDW-1:0]    qd;

  // scope*31 + name, built as a shift, a subtract and an add.
  assign hash = (HASH_W'(scope_id) << 5) - HASH_W'(scope_id) + HASH_W'(name_id);

  // Quotient estimate and its multiple of the bucket count.
  assign prod = PRW'(rem) * PRW'(RECIP);
  assign qd   = QDW'(quo) * QDW'(BUCKETS);

  // A power-of-two bucket count needs no reduction steps.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 2'd0;
    end else if (start) begin
      phase <= POW2 ? 2'd0 : 2'd2;
    end else if (phase != 2'd0) begin
      phase <= phase - 2'd1;
    end
  end

  // Quotient in the first step, remainder in the second.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= hash;
    end else if (phase == 2'd1) begin
      rem <= rem - HASH_W'(qd);
    end
    if (phase == 2'd2) begin
      quo <= HASH_W'(prod >> SH);
    end
  end

  assign done = (phase == 2'd0);
  assign bidx = rem[BIW-1:0];

endmodule

// ----- rtl/scoped_symbol_hash_table.sv -----
// Top level: chained hash table with intern and resolve over three memories.
// An empty bucket is settled by the bucket read, a direct bucket by one key check,
// and a chain by a key check per chain node visited; a second node write may follow.
// A non-power-of-two bucket count adds the hash reduction steps.
// One request is in flight at a time; the next is taken in the cycle in which the result is presented.
// After reset the bucket memory is cleared while requests stall.
module scoped_symbol_hash_table #(
  parameter int BUCKETS     = 4096,
  parameter int MAX_ENTRIES = 4096,
  parameter int MAX_NODES   = 8192
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  sht_pkg::sht_req_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output sht_pkg::sht_rsp_t out_data
);
  import sht_pkg::*;

  localparam int EW  = $clog2(MAX_ENTRIES);
  localparam int ECW = $clog2(MAX_ENTRIES + 1);
  localparam int NW  = $clog2(MAX_NODES);
  localparam int NCW = $clog2(MAX_NODES + 1);
  localparam int BIW = $clog2(BUCKETS);
  localparam int PW  = (EW > NW) ? EW : NW;
  localparam int BWW = PW + 1;
  localparam int NDW = EW + NW;

  sht_state_t state, state_next;

  // Request context.
  logic             op_q;
  logic [KEY_W-1:0] key_q;
  logic [BIW-1:0]   bidx_q;
  logic [BIW-1:0]   clr_q;
  logic [ECW-1:0]   ec;
  logic [NCW-1:0]   nc;
  logic [EW-1:0]    cur_eid;
  logic [NW-1:0]    idx_q;
  logic [NW-1:0]    nn_q;
  logic [NW-1:0]    w2_addr;
  logic [NDW-1:0]   w2_data;
  logic [EW-1:0]    res_id;
  logic             res_found;
  logic             res_full;

  // Memory ports.
  logic             bkt_we, key_we, node_we;
  logic [BIW-1:0]   bkt_waddr, bkt_raddr;
  logic [BWW-1:0]   bkt_wdata, bkt_rdata;
  logic [EW-1:0]    key_waddr, key_raddr;
  logic [KEY_W-1:0] key_wdata, key_rdata;
  logic [NW-1:0]    node_waddr, node_raddr;
  logic [NDW-1:0]   node_wdata, node_rdata;

  // Hash unit.
  logic             h_start, h_done;
  logic [BIW-1:0]   h_bidx;

  // Decisions.
  logic             set_res, ins_entry, ins_node1, ins_node2, idx_ok, load_w2;
  logic [EW-1:0]    fin_id;
  logic             fin_found, fin_full;
  logic [NW-1:0]    w2_addr_next;
  logic [NDW-1:0]   w2_data_next;
  logic [EW-1:0]    ec_id, old_id;
  logic [NW-1:0]    head_idx, nc_idx, nc_p1;
  logic [EW-1:0]    node_ent;
  logic [NW-1:0]    node_nxt;
  logic             eid_ok, hit, room, nroom1, nroom2, out_free, clr_done;

  assign in_stall = (state != ST_IDLE);
  assign h_start  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign clr_done = (clr_q == BIW'(BUCKETS - 1));

  assign ec_id    = ec[EW-1:0];
  assign nc_idx   = nc[NW-1:0];
  assign nc_p1    = NW'(nc + NCW'(1));
  assign old_id   = bkt_rdata[EW:1];
  assign head_idx = bkt_rdata[NW:1];
  assign node_ent = node_rdata[NDW-1:NW];
  assign node_nxt = node_rdata[NW-1:0];

  // Key check of the entry named by cur_eid against the request key.
  assign eid_ok = (cur_eid != '0) && (ECW'(cur_eid) < ec) &&
                  (ECW'(cur_eid) < ECW'(MAX_ENTRIES));
  assign hit    = eid_ok && (key_rdata == key_q);
  assign room   = ec < ECW'(MAX_ENTRIES);
  assign nroom1 = nc < NCW'(MAX_NODES);
  assign nroom2 = ((NCW+1)'(nc) + (NCW+1)'(2)) <= (NCW+1)'(MAX_NODES);
  assign idx_ok = (idx_q != '0) && (NCW'(idx_q) < nc) &&
                  (NCW'(idx_q) < NCW'(MAX_NODES));

  sht_hash #(.BUCKETS(BUCKETS)) u_hash (
    .clk      (clk),
    .rst      (rst),
    .start    (h_start),
    .scope_id (in_data.scope_id),
    .name_id  (in_data.name_id),
    .done     (h_done),
    .bidx     (h_bidx)
  );

  sht_ram #(.WIDTH(BWW), .DEPTH(BUCKETS)) u_bkt (
    .clk (clk), .we (bkt_we), .waddr (bkt_waddr), .wdata (bkt_wdata),
    .raddr (bkt_raddr), .rdata (bkt_rdata)
  );

  sht_ram #(.WIDTH(KEY_W), .DEPTH(MAX_ENTRIES)) u_key (
    .clk (clk), .we (key_we), .waddr (key_waddr), .wdata (key_wdata),
    .raddr (key_raddr), .rdata (key_rdata)
  );

  sht_ram #(.WIDTH(NDW), .DEPTH(MAX_NODES)) u_node (
    .clk (clk), .we (node_we), .waddr (node_waddr), .wdata (node_wdata),
    .raddr (node_raddr), .rdata (node_rdata)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:    if (clr_done) state_next = ST_IDLE;
      ST_IDLE:     if (in_valid) state_next = ST_HASH;
      ST_HASH:     if (h_done) state_next = ST_BKT_RD;
      ST_BKT_RD:   state_next = ST_BKT_EV;
      ST_BKT_EV: begin
        if (bkt_rdata == '0) state_next = ST_DONE;
        else if (!bkt_rdata[0]) state_next = ST_KEY_EV;
        else state_next = ST_NODE_CHK;
      end
      ST_KEY_EV:   state_next = ins_node2 ? ST_NODE_W2 : ST_DONE;
      ST_NODE_CHK: state_next = idx_ok ? ST_NODE_EV : ST_DONE;
      ST_NODE_EV:  state_next = ST_NKEY_EV;
      ST_NKEY_EV: begin
        if (!set_res) state_next = ST_NODE_CHK;
        else if (ins_node1) state_next = ST_NODE_W2;
        else state_next = ST_DONE;
      end
      ST_NODE_W2:  state_next = ST_DONE;
      ST_DONE:     if (out_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // Memory ports and request decisions.
  always_comb begin
    bkt_we       = 1'b0;
    bkt_waddr    = bidx_q;
    bkt_wdata    = '0;
    bkt_raddr    = bidx_q;
    key_we       = 1'b0;
    key_waddr    = ec_id;
    key_wdata    = key_q;
    key_raddr    = cur_eid;
    node_we      = 1'b0;
    node_waddr   = nc_idx;
    node_wdata   = w2_data;
    node_raddr   = idx_q;
    set_res      = 1'b0;
    fin_id       = '0;
    fin_found    = 1'b0;
    fin_full     = 1'b0;
    ins_entry    = 1'b0;
    ins_node1    = 1'b0;
    ins_node2    = 1'b0;
    load_w2      = 1'b0;
    w2_addr_next = nc_p1;
    w2_data_next = {ec_id, NW'(0)};
    unique case (state)
      ST_CLEAR: begin
        bkt_we    = 1'b1;
        bkt_waddr = clr_q;
      end
      ST_BKT_EV: begin
        key_raddr = old_id;
        if (bkt_rdata == '0) begin
          set_res = 1'b1;
          if (op_q == OP_RESOLVE) begin
            fin_id = '0;
          end else if (!room) begin
            fin_full = 1'b1;
          end else begin
            key_we    = 1'b1;
            bkt_we    = 1'b1;
            bkt_wdata = {PW'(ec_id), 1'b0};
            fin_id    = ec_id;
            ins_entry = 1'b1;
          end
        end
      end
      ST_KEY_EV: begin
        set_res = 1'b1;
        if (hit) begin
          fin_id    = cur_eid;
          fin_found = 1'b1;
        end else if (op_q == OP_RESOLVE) begin
          fin_id = '0;
        end else if (!room || !nroom2) begin
          fin_full = 1'b1;
        end else begin
          // Old entry becomes the head node, the new entry the second node.
          key_we       = 1'b1;
          node_we      = 1'b1;
          node_waddr   = nc_idx;
          node_wdata   = {cur_eid, nc_p1};
          bkt_we       = 1'b1;
          bkt_wdata    = {PW'(nc_idx), 1'b1};
          fin_id       = ec_id;
          ins_entry    = 1'b1;
          ins_node2    = 1'b1;
          load_w2      = 1'b1;
          w2_addr_next = nc_p1;
        end
      end
      ST_NODE_CHK: begin
        if (!idx_ok) begin
          set_res = 1'b1;
        end
      end
      ST_NODE_EV: begin
        key_raddr = node_ent;
      end
      ST_NKEY_EV: begin
        if (hit) begin
          set_res   = 1'b1;
          fin_id    = cur_eid;
          fin_found = 1'b1;
        end else if (nn_q == '0) begin
          set_res = 1'b1;
          if (op_q == OP_RESOLVE) begin
            fin_id = '0;
          end else if (!room || !nroom1) begin
            fin_full = 1'b1;
          end else begin
            // Relink the tail to the new node, written in the next cycle.
            key_we       = 1'b1;
            node_we      = 1'b1;
            node_waddr   = idx_q;
            node_wdata   = {cur_eid, nc_idx};
            fin_id       = ec_id;
            ins_entry    = 1'b1;
            ins_node1    = 1'b1;
            load_w2      = 1'b1;
            w2_addr_next = nc_idx;
          end
        end
      end
      ST_NODE_W2: begin
        node_we    = 1'b1;
        node_waddr = w2_addr;
        node_wdata = w2_data;
      end
      default: begin
        bkt_we = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_q <= '0;
      ec    <= ECW'(1);
      nc    <= NCW'(1);
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_q <= clr_q + BIW'(1);
      end
      if (ins_entry) begin
        ec <= ec + ECW'(1);
      end
      if (ins_node2) begin
        nc <= nc + NCW'(2);
      end else if (ins_node1) begin
        nc <= nc + NCW'(1);
      end
    end
  end

  // Request context and chain walk registers.
  always_ff @(posedge clk) begin
    if (h_start) begin
      op_q  <= in_data.op;
      key_q <= {in_data.scope_id, in_data.name_id};
    end
    if (state == ST_HASH) begin
      bidx_q <= h_bidx;
    end
    if (state == ST_BKT_EV) begin
      cur_eid <= old_id;
      idx_q   <= head_idx;
    end
    if (state == ST_NODE_EV) begin
      cur_eid <= node_ent;
      nn_q    <= node_nxt;
    end
    if ((state == ST_NKEY_EV) && !set_res) begin
      idx_q <= nn_q;
    end
    if (load_w2) begin
      w2_addr <= w2_addr_next;
      w2_data <= w2_data_next;
    end
    if (set_res) begin
      res_id    <= fin_id;
      res_found <= fin_found;
      res_full  <= fin_full;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && out_free) begin
      out_data.entry_id <= ID_OUT_W'(res_id);
      out_data.found    <= res_found;
      out_data.full_res <= res_full;
    end
  end

  // Allocation counters only grow and stay within their stores.
  a_ec_mono: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> ec >= $past(ec)) else $error("entry count went backwards");

  a_nc_bound: assert property (@(posedge clk) disable iff (rst)
    nc <= NCW'(MAX_NODES)) else $error("node count beyond store");

  // A result is never both found and refused.
  a_out_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.found && out_data.full_res))
    else $error("found and full together");

  // A refused intern carries no id.
  a_full_id: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.full_res) |-> (out_data.entry_id == '0))
    else $error("full result with nonzero id");

endmodule
